### src/modem_command_stream_parser_macros.svh
// Assertion macros shared by the modem command stream parser checkers.
`ifndef MODEM_COMMAND_STREAM_PARSER_MACROS_SVH
`define MODEM_COMMAND_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MCSP_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("modem command stream parser check failed");

// Next-cycle implication, disabled while reset is high.
`define MCSP_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("modem command stream parser check failed");

// Next-cycle implication that is also checked across reset.
`define MCSP_ASSERT_NEXT_ALWAYS(label, clk, cond, expr) \
   label: assert property (@(posedge clk) (cond) |=> (expr)) \
      else $error("modem command stream parser check failed");

`endif

### src/mcsp_pkg.sv
// Package with the types, codes and helpers of the modem command stream parser.
`timescale 1ns / 1ps

package mcsp_pkg;

   typedef enum logic [3:0] {
      EV_INIT          = 4'd0,
      EV_MODE          = 4'd1,
      EV_STOP          = 4'd2,
      EV_SIZE          = 4'd3,
      EV_ETH_SET       = 4'd4,
      EV_ETH_GET       = 4'd5,
      EV_MOD_COMB      = 4'd6,
      EV_DUC_FREQ      = 4'd7,
      EV_DDC_FREQ      = 4'd8,
      EV_DEM_COMB      = 4'd9,
      EV_INVERSION     = 4'd10,
      EV_DATA_BITS     = 4'd11,
      EV_UNSUPPORTED   = 4'd12,
      EV_BAD_INVERSION = 4'd13,
      EV_TIMEOUT       = 4'd14
   } event_type;

   localparam logic        KIND_BYTE         = 1'b0;
   localparam logic        KIND_TICK         = 1'b1;
   localparam logic [7:0]  DATA_BYTE_MIN     = 8'd192;
   localparam logic [7:0]  COMMAND_LIMIT     = 8'd64;
   localparam logic [7:0]  MAX_COMMAND       = 8'd10;
   localparam logic [7:0]  MAX_INVERSION     = 8'd1;
   localparam logic [15:0] TIMEOUT_RESET     = 16'd1000;
   localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;
   localparam logic [3:0]  FREQ_BYTES        = 4'd4;
   localparam logic [3:0]  ETH_IP_BYTES      = 4'd4;
   localparam logic [3:0]  ETH_MASK_BYTES    = 4'd8;
   localparam logic [3:0]  ETH_TOTAL_BYTES   = 4'd10;
   localparam int          CSR_ADDR_WIDTH    = 2;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_TIMEOUT_ADDR = 2'd0;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } item_type;

   function automatic logic [31:0] swap_bytes(input logic [31:0] x);
      swap_bytes = {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

### src/mcsp_ifs.sv
// Handshake interfaces for the command input and the result output.
`timescale 1ns / 1ps

interface mcsp_req_if import mcsp_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface mcsp_rsp_if import mcsp_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [3:0]  event_res;
   logic [31:0] value;
   logic [31:0] ip_address;
   logic [31:0] net_mask;
   logic [15:0] port_number;
   logic [5:0]  data_bits;

   modport source (output valid, output event_res, output value, output ip_address,
                   output net_mask, output port_number, output data_bits, input ready);
   modport sink (input valid, input event_res, input value, input ip_address,
                 input net_mask, input port_number, input data_bits, output ready);
endinterface

### src/mcsp_csr.sv
// APB register block holding the timeout threshold.
`timescale 1ns / 1ps

module mcsp_csr import mcsp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready,
   output logic [15:0]               timeout_ticks
);

   logic [15:0] timeout_ff;
   logic [15:0] timeout_in;
   logic        write_hit;

   assign pready    = 1'b1;
   assign write_hit = psel && penable && pwrite && pready && (paddr == CSR_TIMEOUT_ADDR);

   always_comb begin
      timeout_in = timeout_ff;
      if (write_hit) begin
         timeout_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   assign prdata        = (paddr == CSR_TIMEOUT_ADDR) ? {16'd0, timeout_ff} : 32'd0;
   assign timeout_ticks = timeout_ff;

endmodule

### src/mcsp_in_stage.sv
// Input register that captures one command byte or tick per transfer.
`timescale 1ns / 1ps

module mcsp_in_stage import mcsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   mcsp_req_if.sink     req_ch,
   output logic         item_valid,
   output item_type     item,
   input  logic         item_take
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     load;

   assign req_ch.ready = !valid_ff || item_take;
   assign load         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in        = 1'b1;
         item_in.kind    = req_ch.kind;
         item_in.rx_byte = req_ch.rx_byte;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### src/mcsp_core.sv
// Parser state and result register: decodes one item per cycle while the result register is free or being taken.
`timescale 1ns / 1ps

module mcsp_core import mcsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  item_type     item,
   output logic         item_take,
   input  logic [15:0]  timeout_ticks,
   mcsp_rsp_if.source   rsp_ch
);

   logic        busy_ff,    busy_in;
   logic [3:0]  cmd_ff,     cmd_in;
   logic [31:0] window_ff,  window_in;
   logic [3:0]  count_ff,   count_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [31:0] ip_ff,      ip_in;
   logic [31:0] mask_ff,    mask_in;

   logic        out_valid_ff, out_valid_in;
   event_type   event_ff,     event_in;
   logic [31:0] value_ff,     value_in;
   logic [31:0] out_ip_ff,    out_ip_in;
   logic [31:0] out_mask_ff,  out_mask_in;
   logic [15:0] port_ff,      port_in;
   logic [5:0]  bits_ff,      bits_in;

   assign item_take = item_valid && (!out_valid_ff || rsp_ch.ready);

   always_comb begin
      logic [31:0] window_new;
      logic [31:0] swapped;
      logic [15:0] elapsed_new;
      logic [3:0]  count_new;
      logic [7:0]  b;
      logic        emit;

      b           = item.rx_byte;
      window_new  = {b, window_ff[31:8]};
      swapped     = swap_bytes(window_new);
      elapsed_new = (elapsed_ff != ELAPSED_MAX) ? elapsed_ff + 16'd1 : elapsed_ff;
      count_new   = count_ff + 4'd1;
      emit        = 1'b0;

      busy_in    = busy_ff;
      cmd_in     = cmd_ff;
      window_in  = window_ff;
      count_in   = count_ff;
      elapsed_in = elapsed_ff;
      ip_in      = ip_ff;
      mask_in    = mask_ff;

      event_in    = EV_INIT;
      value_in    = 32'd0;
      out_ip_in   = 32'd0;
      out_mask_in = 32'd0;
      port_in     = 16'd0;
      bits_in     = 6'd0;

      if (item.kind == KIND_TICK) begin
         if (busy_ff) begin
            elapsed_in = elapsed_new;
            if (elapsed_new >= timeout_ticks) begin
               busy_in  = 1'b0;
               emit     = 1'b1;
               event_in = EV_TIMEOUT;
            end
         end
      end else begin
         window_in = window_new;
         if (busy_ff) begin
            count_in = count_new;
            unique case (cmd_ff)
               EV_MODE, EV_SIZE, EV_MOD_COMB, EV_DEM_COMB: begin
                  busy_in  = 1'b0;
                  emit     = 1'b1;
                  event_in = event_type'(cmd_ff);
                  value_in = {24'd0, b};
               end
               EV_INVERSION: begin
                  busy_in  = 1'b0;
                  emit     = 1'b1;
                  event_in = (b <= MAX_INVERSION) ? EV_INVERSION : EV_BAD_INVERSION;
                  value_in = {24'd0, b};
               end
               EV_DUC_FREQ, EV_DDC_FREQ: begin
                  if (count_new == FREQ_BYTES) begin
                     busy_in  = 1'b0;
                     emit     = 1'b1;
                     event_in = event_type'(cmd_ff);
                     value_in = swapped;
                  end
               end
               EV_ETH_SET: begin
                  if (count_new == ETH_IP_BYTES) begin
                     ip_in = swapped;
                  end
                  if (count_new == ETH_MASK_BYTES) begin
                     mask_in = swapped;
                  end
                  if (count_new == ETH_TOTAL_BYTES) begin
                     busy_in     = 1'b0;
                     emit        = 1'b1;
                     event_in    = EV_ETH_SET;
                     out_ip_in   = ip_ff;
                     out_mask_in = mask_ff;
                     port_in     = window_new[31:16];
                  end
               end
               default: begin
                  busy_in = 1'b0;
               end
            endcase
         end else if (b >= DATA_BYTE_MIN) begin
            emit     = 1'b1;
            event_in = EV_DATA_BITS;
            bits_in  = b[5:0];
         end else if (b < COMMAND_LIMIT) begin
            count_in   = 4'd0;
            elapsed_in = 16'd0;
            if (b == 8'(EV_INIT) || b == 8'(EV_STOP) || b == 8'(EV_ETH_GET)) begin
               emit     = 1'b1;
               event_in = event_type'(b[3:0]);
            end else if (b > MAX_COMMAND) begin
               emit     = 1'b1;
               event_in = EV_UNSUPPORTED;
               value_in = {24'd0, b};
            end else begin
               busy_in = 1'b1;
               cmd_in  = b[3:0];
            end
         end
      end

      if (!item_take) begin
         busy_in    = busy_ff;
         cmd_in     = cmd_ff;
         window_in  = window_ff;
         count_in   = count_ff;
         elapsed_in = elapsed_ff;
         ip_in      = ip_ff;
         mask_in    = mask_ff;
      end

      if (item_take) begin
         out_valid_in = emit;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cmd_ff       <= 4'd0;
         window_ff    <= 32'd0;
         count_ff     <= 4'd0;
         elapsed_ff   <= 16'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cmd_ff       <= cmd_in;
         window_ff    <= window_in;
         count_ff     <= count_in;
         elapsed_ff   <= elapsed_in;
         out_valid_ff <= out_valid_in;
      end
      ip_ff   <= ip_in;
      mask_ff <= mask_in;
      if (item_take) begin
         event_ff    <= event_in;
         value_ff    <= value_in;
         out_ip_ff   <= out_ip_in;
         out_mask_ff <= out_mask_in;
         port_ff     <= port_in;
         bits_ff     <= bits_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.event_res   = event_ff;
   assign rsp_ch.value       = value_ff;
   assign rsp_ch.ip_address  = out_ip_ff;
   assign rsp_ch.net_mask    = out_mask_ff;
   assign rsp_ch.port_number = port_ff;
   assign rsp_ch.data_bits   = bits_ff;

endmodule

### src/modem_command_stream_parser.sv
// Top level of the modem command stream parser.
// Accepts one command byte or millisecond tick per cycle while results are taken, and returns
// at most one event per item. An item passes from the input register to the result register
// of the core, and the input is held back only while a result waits to be taken; the rate is
// set by the single-cycle update of the parser state in the core. The timeout threshold is
// written over APB at address 0 and must only be changed while the block is idle.
`timescale 1ns / 1ps

module modem_command_stream_parser import mcsp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   mcsp_req_if.sink                  req_ch,
   mcsp_rsp_if.source                rsp_ch,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   logic        item_valid;
   item_type    item;
   logic        item_take;
   logic [15:0] timeout_ticks;

   mcsp_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .timeout_ticks (timeout_ticks)
   );

   mcsp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   mcsp_core u_core (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item          (item),
      .item_take     (item_take),
      .timeout_ticks (timeout_ticks),
      .rsp_ch        (rsp_ch)
   );

endmodule

### src/mcsp_checker.sv
// Port-level checker for the modem command stream parser and its bind statement.
`timescale 1ns / 1ps
`include "modem_command_stream_parser_macros.svh"

module mcsp_checker import mcsp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_event_res,
   input logic [31:0] rsp_value,
   input logic [5:0]  rsp_data_bits
);

   `MCSP_ASSERT_NEXT_ALWAYS(a_no_result_after_reset, clock, reset, !rsp_valid)
   `MCSP_ASSERT_NEXT(a_stalled_result_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_res) && $stable(rsp_value))
   `MCSP_ASSERT_NOW(a_data_bits_only_for_data, clock, reset, rsp_valid && rsp_event_res != EV_DATA_BITS, rsp_data_bits == 6'd0)
   `MCSP_ASSERT_NOW(a_unsupported_code_range, clock, reset, rsp_valid && rsp_event_res == EV_UNSUPPORTED, rsp_value > 32'd10 && rsp_value < 32'd64)

endmodule

bind modem_command_stream_parser mcsp_checker u_mcsp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_event_res (rsp_ch.event_res),
   .rsp_value     (rsp_ch.value),
   .rsp_data_bits (rsp_ch.data_bits)
);

### dv/tb.sv
// Self-checking testbench for the modem command stream parser, with event prediction.
`timescale 1ns / 1ps

module tb;
   import mcsp_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_PERCENT  = 22;
   localparam int LONG_TICKS    = 40;

   typedef struct packed {
      event_type   ev;
      logic [31:0] value;
      logic [31:0] ip_address;
      logic [31:0] net_mask;
      logic [15:0] port_number;
      logic [5:0]  data_bits;
   } event_rec;

   class event_checker;
      logic [15:0] timeout_limit = TIMEOUT_RESET;
      bit          collecting    = 1'b0;
      logic [3:0]  active_code   = '0;
      logic [31:0] byte_window   = '0;
      logic [3:0]  byte_count    = '0;
      logic [15:0] tick_count    = '0;
      logic [31:0] held_ip       = '0;
      logic [31:0] held_mask     = '0;
      event_rec    awaited[$];
      int          mismatches    = 0;

      // Works out the event, if any, that one accepted transfer on the input channel causes.
      function void note_item(logic kind, logic [7:0] rx);
         event_rec    ev_out;
         bit          fired;
         logic [31:0] in_order;
         ev_out = '0;
         fired = 1'b0;
         if (kind == KIND_TICK) begin
            if (collecting) begin
               if (tick_count != ELAPSED_MAX) tick_count++;
               if (tick_count >= timeout_limit) begin
                  collecting = 1'b0;
                  ev_out.ev = EV_TIMEOUT;
                  fired = 1'b1;
               end
            end
         end else begin
            byte_window = {rx, byte_window[31:8]};
            in_order = {byte_window[7:0], byte_window[15:8], byte_window[23:16],
                        byte_window[31:24]};
            if (collecting) begin
               byte_count = byte_count + 4'd1;
               case (active_code)
                  EV_MODE, EV_SIZE, EV_MOD_COMB, EV_DEM_COMB: begin
                     collecting = 1'b0;
                     ev_out.ev = event_type'(active_code);
                     ev_out.value = {24'h0, rx};
                     fired = 1'b1;
                  end
                  EV_INVERSION: begin
                     collecting = 1'b0;
                     ev_out.ev = (rx <= MAX_INVERSION) ? EV_INVERSION : EV_BAD_INVERSION;
                     ev_out.value = {24'h0, rx};
                     fired = 1'b1;
                  end
                  EV_DUC_FREQ, EV_DDC_FREQ: begin
                     if (byte_count == FREQ_BYTES) begin
                        collecting = 1'b0;
                        ev_out.ev = event_type'(active_code);
                        ev_out.value = in_order;
                        fired = 1'b1;
                     end
                  end
                  EV_ETH_SET: begin
                     if (byte_count == ETH_IP_BYTES) held_ip = in_order;
                     if (byte_count == ETH_MASK_BYTES) held_mask = in_order;
                     if (byte_count == ETH_TOTAL_BYTES) begin
                        collecting = 1'b0;
                        ev_out.ev = EV_ETH_SET;
                        ev_out.ip_address = held_ip;
                        ev_out.net_mask = held_mask;
                        ev_out.port_number = byte_window[31:16];
                        fired = 1'b1;
                     end
                  end
                  default: collecting = 1'b0;
               endcase
            end else if (rx >= DATA_BYTE_MIN) begin
               ev_out.ev = EV_DATA_BITS;
               ev_out.data_bits = rx[5:0];
               fired = 1'b1;
            end else if (rx < COMMAND_LIMIT) begin
               byte_count = '0;
               tick_count = '0;
               if (rx == EV_INIT || rx == EV_STOP || rx == EV_ETH_GET) begin
                  ev_out.ev = event_type'(rx[3:0]);
                  fired = 1'b1;
               end else if (rx > MAX_COMMAND) begin
                  ev_out.ev = EV_UNSUPPORTED;
                  ev_out.value = {24'h0, rx};
                  fired = 1'b1;
               end else begin
                  collecting = 1'b1;
                  active_code = rx[3:0];
               end
            end
         end
         if (fired) awaited.push_back(ev_out);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_event(event_rec got);
         event_rec want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected event, expected none, got %0d", $time, got.ev);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         compare_field("event_res", want.ev, got.ev);
         compare_field("value", want.value, got.value);
         compare_field("ip_address", want.ip_address, got.ip_address);
         compare_field("net_mask", want.net_mask, got.net_mask);
         compare_field("port_number", want.port_number, got.port_number);
         compare_field("data_bits", want.data_bits, got.data_bits);
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [31:0]               pwdata;
   logic [31:0]               prdata;
   logic                      pready;

   mcsp_req_if req_ch();
   mcsp_rsp_if rsp_ch();

   bit           steady = 1'b0;
   int           items_sent = 0;
   int           quiet_cycles = 0;
   event_checker parser_events = new;

   modem_command_stream_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      event_rec got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.ev          = event_type'(rsp_ch.event_res);
            got.value       = rsp_ch.value;
            got.ip_address  = rsp_ch.ip_address;
            got.net_mask    = rsp_ch.net_mask;
            got.port_number = rsp_ch.port_number;
            got.data_bits   = rsp_ch.data_bits;
            parser_events.check_event(got);
         end
         if (req_ch.valid && req_ch.ready)
            parser_events.note_item(req_ch.kind, req_ch.rx_byte);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_item(input logic kind, input logic [7:0] rx);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= kind;
      req_ch.rx_byte <= rx;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] rx);
      send_item(KIND_BYTE, rx);
   endtask

   task automatic send_tick();
      send_item(KIND_TICK, 8'($urandom));
   endtask

   task automatic hold_input();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // Completes any command still collecting payload, so that the parser rests idle.
   task automatic finish_command();
      hold_input();
      while (parser_events.collecting) begin
         send_byte(8'h00);
         hold_input();
      end
   endtask

   task automatic wait_for_events();
      hold_input();
      while (parser_events.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] limit);
      finish_command();
      wait_for_events();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_TIMEOUT_ADDR;
      pwdata  <= {16'h0, limit};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      parser_events.timeout_limit = limit;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[15:0] !== limit) begin
         $display("%0t: timeout_ticks read-back mismatch, expected %0h, got %0h",
                  $time, limit, prdata[15:0]);
         parser_events.mismatches++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Mostly complete commands with random payload, some with ticks in between or cut short,
   // and the rest stray bytes and ticks.
   task automatic send_random_sequence();
      int          pick;
      int          length;
      event_type   code;
      logic [7:0]  payload;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_tick();
      end else if (pick < 18) begin
         send_byte(8'($urandom_range(255, COMMAND_LIMIT)));
      end else if (pick < 25) begin
         send_byte(8'($urandom_range(COMMAND_LIMIT - 1)));
      end else begin
         code = event_type'($urandom_range(MAX_COMMAND));
         case (code)
            EV_INIT, EV_STOP, EV_ETH_GET: length = 0;
            EV_DUC_FREQ, EV_DDC_FREQ:     length = FREQ_BYTES;
            EV_ETH_SET:                   length = ETH_TOTAL_BYTES;
            default:                      length = 1;
         endcase
         if ($urandom_range(99) < 8) length = $urandom_range(length);
         send_byte(8'(code));
         repeat (length) begin
            if ($urandom_range(99) < 12) repeat ($urandom_range(3, 1)) send_tick();
            if (code == EV_INVERSION && $urandom_range(1))
               payload = 8'($urandom_range(MAX_INVERSION + 1));
            else
               payload = 8'($urandom);
            send_byte(payload);
         end
      end
   endtask

   task automatic run_random(input int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) send_random_sequence();
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.kind    = KIND_BYTE;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = CSR_TIMEOUT_ADDR;
      pwdata         = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_tick();
      send_byte(DATA_BYTE_MIN);
      send_byte(8'hFF);
      send_byte(COMMAND_LIMIT);
      send_byte(DATA_BYTE_MIN - 8'd1);
      send_byte(8'(EV_INIT));
      send_byte(8'(EV_STOP));
      send_byte(8'(EV_ETH_GET));
      send_byte(MAX_COMMAND + 8'd1);
      send_byte(COMMAND_LIMIT - 8'd1);
      send_byte(8'(EV_MODE));
      send_byte(8'hFF);
      send_byte(8'(EV_INVERSION));
      send_byte(MAX_INVERSION);
      send_byte(8'(EV_INVERSION));
      send_byte(MAX_INVERSION + 8'd1);
      send_byte(8'(EV_DDC_FREQ));
      send_byte(8'h80);
      send_byte(8'h01);
      send_byte(8'hFE);
      send_byte(8'h7F);

      write_timeout(16'd1);
      send_byte(8'(EV_DEM_COMB));
      send_tick();
      run_random(150);

      write_timeout(16'd0);
      send_byte(8'(EV_SIZE));
      send_tick();
      run_random(100);

      write_timeout(16'd7);
      steady = 1'b1;
      run_random(150);
      steady = 1'b0;

      write_timeout(ELAPSED_MAX);
      finish_command();
      send_byte(8'(EV_DUC_FREQ));
      repeat (LONG_TICKS) send_tick();
      run_random(150);

      write_timeout(16'd20);
      run_random(120);
      wait_for_events();
      run_random(130);

      wait_for_events();
      if (parser_events.mismatches == 0 && parser_events.awaited.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
